// ===== rtl/csvrfe_pkg.sv =====
package csvrfe_pkg;

   // line status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_NA      = 3'd2;
   localparam logic [2:0] ST_LONG    = 3'd3;
   localparam logic [2:0] ST_MISSING = 3'd4;

   // csr register indexes
   localparam logic CSR_ORIGIN_COMMA = 1'b0;
   localparam logic CSR_DEST_COMMA   = 1'b1;

   // csr reset values
   localparam logic [7:0] ORIGIN_COMMA_RST = 8'd17;
   localparam logic [7:0] DEST_COMMA_RST   = 8'd18;

   // characters of interest
   localparam logic [7:0]  CHAR_COMMA = 8'h2C;
   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [15:0] NA_WORD    = 16'h4E41;
   localparam logic [7:0]  COMMA_MAX  = 8'hFF;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [23:0] origin_code;
      logic [23:0] dest_code;
      logic [2:0]  line_status;
   } rsp_word_type;

   // step control from the input stage to the scanner
   typedef struct packed {
      logic step;
      logic last;
   } scan_ctl_type;

endpackage

// ===== rtl/csvrfe_scan.sv =====
module csvrfe_scan
   import csvrfe_pkg::*;
#(
   parameter int MAX_CODE_CHARS = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  scan_ctl_type ctl,
   input  logic [7:0]   char_byte,
   input  logic [7:0]   origin_comma,
   input  logic [7:0]   destination_comma,
   output rsp_word_type result
);

   localparam int BUF_W = 8 * MAX_CODE_CHARS;
   localparam int LEN_W = $clog2(MAX_CODE_CHARS + 2);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_CHARS);
   localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);

   logic [7:0]       comma_ff, comma_in, comma_scan;
   logic [LEN_W-1:0] len_ff, len_in, len_scan;
   logic [BUF_W-1:0] buf_ff, buf_in, buf_scan;
   logic [BUF_W-1:0] org_ff, org_in, org_scan;
   logic [BUF_W-1:0] dst_ff, dst_in, dst_scan;
   logic [1:0]       found_ff, found_in, found_scan;
   logic [2:0]       err_ff, err_in, err_scan;
   logic             stop_ff, stop_in, stop_scan;

   logic [7:0]       comma_next;
   logic             counted;
   logic             is_org;
   logic             is_dst;
   logic [BUF_W-1:0] aligned;
   logic [2:0]       status;

   // field under the current comma, left aligned in the code width
   assign aligned = buf_ff << (8 * (MAX_CODE_CHARS - int'(len_ff)));

   assign counted    = (comma_ff != COMMA_MAX);
   assign comma_next = comma_ff + 8'd1;
   assign is_org     = counted && (origin_comma != 8'd0) && (comma_next == origin_comma);
   assign is_dst     = counted && (destination_comma != 8'd0)
                       && (comma_next == destination_comma);

   // scan one byte into the line state
   always_comb begin
      comma_scan = comma_ff;
      len_scan   = len_ff;
      buf_scan   = buf_ff;
      org_scan   = org_ff;
      dst_scan   = dst_ff;
      found_scan = found_ff;
      err_scan   = err_ff;
      stop_scan  = stop_ff;
      if (!stop_ff) begin
         if (char_byte == CHAR_NUL) begin
            stop_scan = 1'b1;
         end else if (char_byte == CHAR_COMMA) begin
            if (counted) begin
               comma_scan = comma_next;
            end
            if (is_org || is_dst) begin
               if (len_ff == '0) begin
                  err_scan = ST_EMPTY;
               end else if (len_ff > LEN_MAX) begin
                  err_scan = ST_LONG;
               end else if (len_ff == LEN_TWO && buf_ff == BUF_W'(NA_WORD)) begin
                  err_scan = ST_NA;
               end else begin
                  if (is_org) begin
                     org_scan = aligned;
                  end else begin
                     dst_scan = aligned;
                  end
                  if (found_ff != 2'd3) begin
                     found_scan = found_ff + 2'd1;
                  end
               end
               if (err_scan != ST_OK) begin
                  stop_scan = 1'b1;
               end
            end
            len_scan = '0;
            buf_scan = '0;
         end else if (len_ff <= LEN_MAX) begin
            buf_scan = (buf_ff << 8) | BUF_W'(char_byte);
            len_scan = len_ff + LEN_W'(1);
         end
      end
   end

   // line result from the state after this byte
   always_comb begin
      if (err_scan != ST_OK) begin
         status = err_scan;
      end else if (found_scan < 2'd2) begin
         status = ST_MISSING;
      end else begin
         status = ST_OK;
      end
      result.line_status = status;
      result.origin_code = (status == ST_OK) ? 24'(org_scan) : 24'd0;
      result.dest_code   = (status == ST_OK) ? 24'(dst_scan) : 24'd0;
   end

   // next line state: cleared after the last byte
   always_comb begin
      comma_in = comma_ff;
      len_in   = len_ff;
      buf_in   = buf_ff;
      org_in   = org_ff;
      dst_in   = dst_ff;
      found_in = found_ff;
      err_in   = err_ff;
      stop_in  = stop_ff;
      if (ctl.step) begin
         if (ctl.last) begin
            comma_in = '0;
            len_in   = '0;
            buf_in   = '0;
            org_in   = '0;
            dst_in   = '0;
            found_in = '0;
            err_in   = ST_OK;
            stop_in  = 1'b0;
         end else begin
            comma_in = comma_scan;
            len_in   = len_scan;
            buf_in   = buf_scan;
            org_in   = org_scan;
            dst_in   = dst_scan;
            found_in = found_scan;
            err_in   = err_scan;
            stop_in  = stop_scan;
         end
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         comma_ff <= '0;
         len_ff   <= '0;
         buf_ff   <= '0;
         org_ff   <= '0;
         dst_ff   <= '0;
         found_ff <= '0;
         err_ff   <= ST_OK;
         stop_ff  <= 1'b0;
      end else begin
         comma_ff <= comma_in;
         len_ff   <= len_in;
         buf_ff   <= buf_in;
         org_ff   <= org_in;
         dst_ff   <= dst_in;
         found_ff <= found_in;
         err_ff   <= err_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

// ===== rtl/csvrfe_out_reg.sv =====
module csvrfe_out_reg
   import csvrfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type load_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   // hold the word until the receiver takes it
   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = load_word;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/csv_route_field_extractor.sv =====
// csv_route_field_extractor: pulls two airport codes out of a csv line
//
// req channel: one byte of the line per word, last_byte marks the line end.
// rsp channel: one word per line with origin code, destination code and a
//   status (ok, empty field, NA field, field too long, field missing).
// csr port: index 0 sets the comma ordinal closing the origin field, index 1
//   the one closing the destination field; write only while the block is idle.
// result path: a last byte passes the input register, then the result register, before
//   its result shows on rsp.
// throughput: one byte per cycle, unless a last byte waits on a result not yet taken;
//   the scan step between the input register and the line state is combinational.
// reset: clears the line state and both valid flags, and loads the comma
//   ordinals 17 and 18.
// stall: a result waiting in the output register does not block the stream;
//   bytes of the next line keep flowing until another last byte reaches the
//   input register, which then holds until the receiver takes the result.
module csv_route_field_extractor
   import csvrfe_pkg::*;
#(
   parameter int MAX_CODE_CHARS = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [7:0]   csr_data
);

   logic [7:0]   origin_comma_ff, origin_comma_in;
   logic [7:0]   dest_comma_ff, dest_comma_in;
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         in_go;
   scan_ctl_type ctl;
   rsp_word_type result;

   // csr registers
   always_comb begin
      origin_comma_in = origin_comma_ff;
      dest_comma_in   = dest_comma_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_COMMA: origin_comma_in = csr_data;
            CSR_DEST_COMMA:   dest_comma_in   = csr_data;
            default:          origin_comma_in = origin_comma_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_comma_ff <= ORIGIN_COMMA_RST;
         dest_comma_ff   <= DEST_COMMA_RST;
      end else begin
         origin_comma_ff <= origin_comma_in;
         dest_comma_ff   <= dest_comma_in;
      end
   end

   // input register: a last byte waits only for a free result register
   assign in_go     = !in_word_ff.last_byte || !rsp_valid || rsp_ready;
   assign req_ready = !in_valid_ff || in_go;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (in_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   assign ctl.step = in_valid_ff && in_go;
   assign ctl.last = in_word_ff.last_byte;

   csvrfe_scan #(
      .MAX_CODE_CHARS (MAX_CODE_CHARS)
   ) u_scan (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .char_byte         (in_word_ff.char_byte),
      .origin_comma      (origin_comma_ff),
      .destination_comma (dest_comma_ff),
      .result            (result)
   );

   csvrfe_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (ctl.step && ctl.last),
      .load_word (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== rtl/csvrfe_checker.sv =====
module csvrfe_checker
   import csvrfe_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   // status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.line_status == ST_OK || rsp_word.line_status == ST_EMPTY
                     || rsp_word.line_status == ST_NA || rsp_word.line_status == ST_LONG
                     || rsp_word.line_status == ST_MISSING))
      else $error("undefined line status");

   // a failed line carries no codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.line_status != ST_OK
      |-> rsp_word.origin_code == 24'd0 && rsp_word.dest_code == 24'd0)
      else $error("codes on a failed line");

   // nothing is shown right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // an accepted line end reaches rsp through the input and result registers when the output is free
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_word.last_byte) ##1 !rsp_valid |=> rsp_valid)
      else $error("line result lost");

endmodule

bind csv_route_field_extractor csvrfe_checker u_checker (.*);

// ===== sim/csv_route_field_extractor_tb.sv =====
`timescale 1ns / 1ps

module csv_route_field_extractor_tb;
   import csvrfe_pkg::*;

   localparam int MAX_CODE_CHARS = 3;
   localparam int ITEM_TARGET    = 1950;
   localparam int TAIL_ITEMS     = 300;
   localparam int LONG_HOLD      = 300;
   localparam int QUIET_LIMIT    = 3000;
   localparam int REPORT_LINES   = 100;

   typedef enum int {
      FIELD_CODE,
      FIELD_EMPTY,
      FIELD_NA,
      FIELD_LONG,
      FIELD_NUL,
      FIELD_JUNK
   } field_kind_type;

   // tracks one csv line and predicts the code pair word it closes with
   class route_pair_checker;
      bit [7:0]     origin_ordinal;
      bit [7:0]     dest_ordinal;
      bit [7:0]     comma_total;
      bit [2:0]     field_chars;
      bit [31:0]    field_text;
      bit [23:0]    origin_text;
      bit [23:0]    dest_text;
      bit [1:0]     codes_found;
      bit [2:0]     line_error;
      bit           scan_halted;
      rsp_word_type pending_pairs[$];
      int           mismatches;

      function new();
         origin_ordinal = ORIGIN_COMMA_RST;
         dest_ordinal   = DEST_COMMA_RST;
         mismatches     = 0;
         clear_line();
      endfunction

      function void clear_line();
         comma_total = '0;
         field_chars = '0;
         field_text  = '0;
         origin_text = '0;
         dest_text   = '0;
         codes_found = '0;
         line_error  = ST_OK;
         scan_halted = 1'b0;
      endfunction

      // a comma closes the field in progress
      function void close_field(bit counted);
         bit        to_origin;
         bit        to_dest;
         bit [31:0] aligned;
         to_origin = counted && origin_ordinal != 0 && comma_total == origin_ordinal;
         to_dest   = counted && dest_ordinal != 0 && comma_total == dest_ordinal;
         if (to_origin || to_dest) begin
            if (field_chars == 0) begin
               line_error = ST_EMPTY;
            end else if (field_chars > MAX_CODE_CHARS) begin
               line_error = ST_LONG;
            end else if (field_chars == 2 && field_text == {16'h0000, NA_WORD}) begin
               line_error = ST_NA;
            end else begin
               aligned = field_text << (8 * (MAX_CODE_CHARS - field_chars));
               if (to_origin) begin
                  origin_text = aligned[23:0];
               end else begin
                  dest_text = aligned[23:0];
               end
               if (codes_found != 2'd3) begin
                  codes_found++;
               end
            end
            if (line_error != ST_OK) begin
               scan_halted = 1'b1;
            end
         end
         field_chars = '0;
         field_text  = '0;
      endfunction

      // called for every accepted req word
      function void take_byte(req_word_type w);
         bit           counted;
         rsp_word_type pair;
         if (!scan_halted) begin
            if (w.char_byte == CHAR_NUL) begin
               scan_halted = 1'b1;
            end else if (w.char_byte == CHAR_COMMA) begin
               counted = comma_total != COMMA_MAX;
               if (counted) begin
                  comma_total++;
               end
               close_field(counted);
            end else if (field_chars <= MAX_CODE_CHARS) begin
               field_text = {field_text[23:0], w.char_byte};
               field_chars++;
            end
         end
         if (w.last_byte) begin
            if (line_error != ST_OK) begin
               pair.line_status = line_error;
            end else if (codes_found < 2) begin
               pair.line_status = ST_MISSING;
            end else begin
               pair.line_status = ST_OK;
            end
            pair.origin_code = (pair.line_status == ST_OK) ? origin_text : '0;
            pair.dest_code   = (pair.line_status == ST_OK) ? dest_text : '0;
            pending_pairs.push_back(pair);
            clear_line();
         end
      endfunction

      task report_mismatch(string what);
         if (mismatches < REPORT_LINES) begin
            $display("%0t mismatch: %s", $realtime, what);
         end
         mismatches++;
      endtask

      // called for every accepted rsp word
      task check_pair(rsp_word_type got);
         rsp_word_type want;
         if (pending_pairs.size() == 0) begin
            report_mismatch($sformatf("rsp word %h with no line pending", got));
         end else begin
            want = pending_pairs.pop_front();
            if (got.origin_code !== want.origin_code) begin
               report_mismatch($sformatf("origin_code %h, want %h",
                                         got.origin_code, want.origin_code));
            end
            if (got.dest_code !== want.dest_code) begin
               report_mismatch($sformatf("dest_code %h, want %h",
                                         got.dest_code, want.dest_code));
            end
            if (got.line_status !== want.line_status) begin
               report_mismatch($sformatf("line_status %0d, want %0d",
                                         got.line_status, want.line_status));
            end
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write;
   logic         csr_index;
   logic [7:0]   csr_data;

   route_pair_checker route_pairs;
   bit [7:0]          line_bytes[$];
   bit [7:0]          cur_origin = ORIGIN_COMMA_RST;
   bit [7:0]          cur_dest   = DEST_COMMA_RST;
   bit                idle_on = 1'b0;
   bit                long_hold_go = 1'b0;
   int                ready_hold = 0;
   int                quiet_cycles = 0;
   int                bytes_sent = 0;

   csv_route_field_extractor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // rsp side: check each accepted word, stall in bursts or one long hold
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         route_pairs.check_pair(rsp_word);
      end
      if (ready_hold != 0) begin
         ready_hold--;
         rsp_ready <= 1'b0;
      end else if (long_hold_go) begin
         long_hold_go = 1'b0;
         ready_hold = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         ready_hold = $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL csv_route_field_extractor");
         $finish;
      end
   end

   // offer one byte and hold it until accepted, then maybe pause
   task automatic send_word(input bit [7:0] ch, input bit last);
      int           gap;
      req_word_type w;
      w.char_byte = ch;
      w.last_byte = last;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      route_pairs.take_byte(w);
      bytes_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_bytes.size(); i++) begin
         send_word(line_bytes[i], i == line_bytes.size() - 1);
      end
   endtask

   // stop offering and wait for every pending line result
   task automatic drain_pairs();
      req_valid <= 1'b0;
      while (route_pairs.pending_pairs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_ordinals(input bit [7:0] origin, input bit [7:0] dest);
      drain_pairs();
      csr_write <= 1'b1;
      csr_index <= CSR_ORIGIN_COMMA;
      csr_data  <= origin;
      @(posedge clock);
      csr_index <= CSR_DEST_COMMA;
      csr_data  <= dest;
      @(posedge clock);
      csr_write <= 1'b0;
      route_pairs.origin_ordinal = origin;
      route_pairs.dest_ordinal   = dest;
      cur_origin = origin;
      cur_dest   = dest;
   endtask

   function automatic bit [7:0] code_char();
      bit [7:0] c;
      if ($urandom_range(0, 4) != 0) begin
         c = 8'($urandom_range(65, 90));
      end else begin
         c = 8'($urandom_range(1, 255));
      end
      if (c == CHAR_COMMA) begin
         c = "Q";
      end
      return c;
   endfunction

   function automatic void push_field(field_kind_type kind);
      int       n;
      bit [7:0] c;
      case (kind)
         FIELD_CODE: begin
            n = $urandom_range(1, MAX_CODE_CHARS);
            repeat (n) line_bytes.push_back(code_char());
         end
         FIELD_NA: begin
            // the exact marker in two of five cases, else a near miss
            case ($urandom_range(0, 4))
               0: line_bytes.push_back("N");
               1: begin
                  line_bytes.push_back("N");
                  line_bytes.push_back("A");
                  line_bytes.push_back("A");
               end
               2: begin
                  line_bytes.push_back("A");
                  line_bytes.push_back("N");
               end
               default: begin
                  line_bytes.push_back("N");
                  line_bytes.push_back("A");
               end
            endcase
         end
         FIELD_LONG: begin
            n = $urandom_range(MAX_CODE_CHARS + 1, 9);
            repeat (n) line_bytes.push_back(code_char());
         end
         FIELD_NUL: begin
            n = $urandom_range(0, 2);
            repeat (n) line_bytes.push_back(code_char());
            line_bytes.push_back(CHAR_NUL);
            n = $urandom_range(0, 2);
            repeat (n) line_bytes.push_back(code_char());
         end
         FIELD_JUNK: begin
            n = $urandom_range(0, 5);
            repeat (n) begin
               c = 8'($urandom_range(1, 255));
               line_bytes.push_back(c == CHAR_COMMA ? 8'hAC : c);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic field_kind_type chosen_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return FIELD_CODE;
      if (r < 78) return FIELD_EMPTY;
      if (r < 86) return FIELD_NA;
      if (r < 93) return FIELD_LONG;
      return FIELD_NUL;
   endfunction

   function automatic field_kind_type other_kind(bit sparse);
      int r;
      r = $urandom_range(0, 99);
      if (sparse) return (r < 85) ? FIELD_EMPTY : FIELD_CODE;
      if (r < 45) return FIELD_CODE;
      if (r < 60) return FIELD_EMPTY;
      if (r < 75) return FIELD_LONG;
      if (r < 96) return FIELD_JUNK;
      return FIELD_NUL;
   endfunction

   // a line of comma separated fields, selected fields mostly well formed
   function automatic void build_line(int commas, bit sparse);
      int i;
      bit chosen;
      line_bytes.delete();
      for (i = 0; i <= commas; i++) begin
         chosen = i < commas && (i + 1 == cur_origin || i + 1 == cur_dest);
         push_field(chosen ? chosen_kind() : other_kind(sparse));
         if (i < commas) begin
            line_bytes.push_back(CHAR_COMMA);
         end
      end
      if (line_bytes.size() == 0) begin
         line_bytes.push_back(code_char());
      end
   endfunction

   task automatic random_line(bit sparse);
      int deepest;
      int r;
      int keep;
      int n;
      deepest = (cur_origin > cur_dest) ? cur_origin : cur_dest;
      r = $urandom_range(0, 99);
      if (sparse || r < 75) begin
         build_line(deepest + $urandom_range(0, 3), sparse);
      end else if (r < 83) begin
         // one comma short of the deepest field
         build_line((deepest > 0) ? deepest - 1 : 0, 1'b0);
      end else if (r < 91) begin
         // line cut off early
         build_line(deepest + 1, 1'b0);
         keep = $urandom_range(1, line_bytes.size());
         while (line_bytes.size() > keep) void'(line_bytes.pop_back());
      end else begin
         // raw noise with frequent commas
         line_bytes.delete();
         n = $urandom_range(1, 24);
         repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 6) begin
               line_bytes.push_back(CHAR_COMMA);
            end else if (r == 6) begin
               line_bytes.push_back(CHAR_NUL);
            end else begin
               line_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
      send_line();
   endtask

   initial begin
      int       k;
      int       phase_start;
      int       budget;
      bit       sparse;
      bit [7:0] org;
      bit [7:0] dst;
      route_pairs = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_ORIGIN_COMMA;
      csr_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ordinals straight out of reset
      idle_on = 1'b1;
      repeat (3) random_line(1'b0);

      // directed lines with origin on the first comma, destination on the second
      set_ordinals(8'd1, 8'd2);
      line_bytes = '{8'hFF, 8'h01, CHAR_COMMA, "Z", CHAR_COMMA};
      send_line();
      line_bytes = '{CHAR_COMMA, "A", "B", CHAR_COMMA};
      send_line();
      line_bytes = '{"N", "A", CHAR_COMMA, "B", CHAR_COMMA};
      send_line();
      line_bytes = '{"A", "B", "C", "D", CHAR_COMMA};
      send_line();
      line_bytes = '{"A", CHAR_NUL, CHAR_COMMA, "B", CHAR_COMMA};
      send_line();
      line_bytes = '{8'h80};
      send_line();

      // random phases, each under its own pair of ordinals
      k = 0;
      while (bytes_sent < ITEM_TARGET) begin
         case (k)
            0: begin org = 8'd2;   dst = 8'd1;   end
            1: begin org = 8'd3;   dst = 8'd3;   end
            2: begin org = 8'd0;   dst = 8'd2;   end
            3: begin org = 8'd255; dst = 8'd254; end
            4: begin org = 8'd254; dst = 8'd255; end
            default: begin
               org = 8'($urandom_range(1, 6));
               dst = 8'($urandom_range(1, 6));
               if ($urandom_range(0, 5) == 0) begin
                  dst = 8'($urandom_range(1, 40));
               end
            end
         endcase
         idle_on = (bytes_sent < ITEM_TARGET - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
         set_ordinals(org, dst);
         // rsp side holds off while lines keep coming, so the input backs up
         if (k == 1) begin
            long_hold_go = 1'b1;
         end
         sparse = (org > 200) || (dst > 200);
         budget = sparse ? 1 : $urandom_range(80, 160);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < budget) random_line(sparse);
         k++;
      end

      drain_pairs();
      repeat (4) @(posedge clock);
      if (route_pairs.mismatches == 0 && route_pairs.pending_pairs.size() == 0) begin
         $display("PASS csv_route_field_extractor");
      end else begin
         $display("FAIL csv_route_field_extractor");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/csvrfe_pkg.sv
rtl/csvrfe_scan.sv
rtl/csvrfe_out_reg.sv
rtl/csv_route_field_extractor.sv
rtl/csvrfe_checker.sv
sim/csv_route_field_extractor_tb.sv
